// ----- rtl/eos_pkg.sv -----
`default_nettype none

package eos_pkg;

    localparam int NUM_FLOORS = 4;
    localparam int IDX_W      = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
    localparam int FLOOR_W    = 2;
    localparam int CMP_W      = (IDX_W > FLOOR_W) ? IDX_W : FLOOR_W;
    localparam int ORDER_W    = 3;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] BTN_UP   = 2'd0;
    localparam logic [1:0] BTN_DOWN = 2'd1;
    localparam logic [1:0] BTN_CAB  = 2'd2;

    localparam int BIT_UP   = 0;
    localparam int BIT_DOWN = 1;
    localparam int BIT_CAB  = 2;

    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             load_in;
        logic             scan_en;
        logic             scan_first;
        logic [IDX_W-1:0] scan_idx;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] floor_idx;
    } target_t;

endpackage

`default_nettype wire

// ----- rtl/elevator_order_scheduler.sv -----
// Elevator order scheduler: keeps the pending hall-up, hall-down and cab
// orders of every floor and answers one request at a time.
// The request channel (s_valid, s_ready) carries mode, button, floor and
// direction. Add sets one order bit, remove clears the orders served at
// the floor, and query changes nothing.
// The result channel (m_valid, m_ready) returns the addressed order bit,
// the stop decision, the next target floor and an any-pending flag, all
// computed from the orders after the update.
// A request is taken in the idle state, then the floor scan reads one
// floor of the order store per cycle, from the bottom floor to the top,
// and a finish state loads the result register once it is free. A new
// request is taken only back in the idle state, after the previous one
// has been loaded into the result register.
// The result register frees the request side: a new request is accepted
// and scanned while the previous result waits, and only loading the next
// result waits for the receiver to take the old one.
// The synchronous active-low reset clears all pending orders, empties the
// result register and returns the controller to idle.
`default_nettype none

module elevator_order_scheduler (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_mode,
    input  wire logic [1:0]                   s_button,
    input  wire logic [eos_pkg::FLOOR_W-1:0]  s_floor,
    input  wire logic signed [1:0]            s_direction,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_order_set,
    output logic                              m_stop_here,
    output logic                              m_target_found,
    output logic [eos_pkg::FLOOR_W-1:0]       m_target_floor,
    output logic                              m_any_pending
);

    eos_pkg::cmd_t    cmd;
    eos_pkg::status_t status;

    eos_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    eos_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_mode         (s_mode),
        .s_button       (s_button),
        .s_floor        (s_floor),
        .s_direction    (s_direction),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_order_set    (m_order_set),
        .m_stop_here    (m_stop_here),
        .m_target_found (m_target_found),
        .m_target_floor (m_target_floor),
        .m_any_pending  (m_any_pending)
    );

    // An accepted request always starts the scan at the bottom floor.
    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.scan_en && cmd.scan_first && !s_ready))
        else $error("accepted request did not start the floor scan");

    // Loading a result always presents it on the next cycle.
    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("loaded result is not presented");

    // A target can only exist while some order is pending.
    a_target_needs_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_target_found) |-> m_any_pending)
        else $error("target reported with no pending order");

    // The result register is never overwritten while it holds an untaken result.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !cmd.load_out)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- rtl/eos_ctrl.sv -----
`default_nettype none

module eos_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire eos_pkg::status_t status,
    output eos_pkg::cmd_t         cmd
);

    eos_pkg::state_t              state_reg;
    eos_pkg::state_t              state_next;
    logic [eos_pkg::IDX_W-1:0]    idx_reg;
    logic [eos_pkg::IDX_W-1:0]    idx_next;
    logic                         last_idx;

    assign last_idx = (idx_reg == eos_pkg::IDX_W'(eos_pkg::NUM_FLOORS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eos_pkg::ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            eos_pkg::ST_IDLE: begin
                idx_next = '0;
                if (s_valid) begin
                    state_next = eos_pkg::ST_SCAN;
                end
            end
            eos_pkg::ST_SCAN: begin
                if (last_idx) begin
                    state_next = eos_pkg::ST_FINISH;
                    idx_next   = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            eos_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    state_next = eos_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = eos_pkg::ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.load_in    = 1'b0;
        cmd.scan_en    = 1'b0;
        cmd.scan_first = 1'b0;
        cmd.scan_idx   = idx_reg;
        cmd.load_out   = 1'b0;
        case (state_reg)
            eos_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            eos_pkg::ST_SCAN: begin
                cmd.scan_en    = 1'b1;
                cmd.scan_first = (idx_reg == '0);
            end
            eos_pkg::ST_FINISH: begin
                cmd.load_out = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/eos_datapath.sv -----
`default_nettype none

module eos_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire eos_pkg::cmd_t                 cmd,
    output eos_pkg::status_t                   status,
    input  wire logic [1:0]                    s_mode,
    input  wire logic [1:0]                    s_button,
    input  wire logic [eos_pkg::FLOOR_W-1:0]   s_floor,
    input  wire logic signed [1:0]             s_direction,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_order_set,
    output logic                               m_stop_here,
    output logic                               m_target_found,
    output logic [eos_pkg::FLOOR_W-1:0]        m_target_floor,
    output logic                               m_any_pending
);

    localparam int IW = eos_pkg::IDX_W;
    localparam int OW = eos_pkg::ORDER_W;

    function automatic eos_pkg::target_t select_up(input logic [OW-1:0] v,
                                                   input logic [OW-1:0][IW-1:0] h);
        eos_pkg::target_t t;
        t.found     = 1'b0;
        t.floor_idx = '0;
        if (v[eos_pkg::BIT_CAB]) begin
            t.found     = 1'b1;
            t.floor_idx = h[eos_pkg::BIT_CAB];
        end else if (v[eos_pkg::BIT_DOWN] && (!v[eos_pkg::BIT_UP] ||
                     h[eos_pkg::BIT_DOWN] > h[eos_pkg::BIT_UP])) begin
            t.found     = 1'b1;
            t.floor_idx = h[eos_pkg::BIT_DOWN];
        end else if (v[eos_pkg::BIT_UP]) begin
            t.found     = 1'b1;
            t.floor_idx = h[eos_pkg::BIT_UP];
        end
        return t;
    endfunction

    function automatic eos_pkg::target_t select_down(input logic [OW-1:0] v,
                                                     input logic [OW-1:0][IW-1:0] h);
        eos_pkg::target_t t;
        t.found     = 1'b0;
        t.floor_idx = '0;
        if (v[eos_pkg::BIT_CAB]) begin
            t.found     = 1'b1;
            t.floor_idx = h[eos_pkg::BIT_CAB];
        end else if (v[eos_pkg::BIT_DOWN] && v[eos_pkg::BIT_UP] &&
                     h[eos_pkg::BIT_DOWN] > h[eos_pkg::BIT_UP]) begin
            t.found     = 1'b1;
            t.floor_idx = h[eos_pkg::BIT_UP];
        end else if (v[eos_pkg::BIT_DOWN]) begin
            t.found     = 1'b1;
            t.floor_idx = h[eos_pkg::BIT_DOWN];
        end else if (v[eos_pkg::BIT_UP]) begin
            t.found     = 1'b1;
            t.floor_idx = h[eos_pkg::BIT_UP];
        end
        return t;
    endfunction

    logic [OW-1:0]                     pending_reg [eos_pkg::NUM_FLOORS];

    logic [1:0]                        mode_reg;
    logic [1:0]                        button_reg;
    logic [eos_pkg::FLOOR_W-1:0]       floor_reg;
    logic signed [1:0]                 dir_reg;

    logic [OW-1:0]                     up_vld_reg;
    logic [OW-1:0]                     up_vld_next;
    logic [OW-1:0][IW-1:0]             up_hit_reg;
    logic [OW-1:0][IW-1:0]             up_hit_next;
    logic [OW-1:0]                     dn_vld_reg;
    logic [OW-1:0]                     dn_vld_next;
    logic [OW-1:0][IW-1:0]             dn_hit_reg;
    logic [OW-1:0][IW-1:0]             dn_hit_next;
    logic                              any_reg;
    logic                              any_next;
    logic [OW-1:0]                     cur_entry_reg;
    logic [OW-1:0]                     cur_entry_next;
    logic                              cur_vld_reg;
    logic                              cur_vld_next;

    logic                              out_valid_reg;
    logic                              order_set_reg;
    logic                              stop_here_reg;
    logic                              target_found_reg;
    logic [eos_pkg::FLOOR_W-1:0]       target_floor_reg;
    logic                              any_pending_reg;

    logic [OW-1:0]                     entry;
    logic [OW-1:0]                     entry_new;
    logic [1:0]                        hall;
    logic                              at_cur;
    logic                              above_cur;
    logic                              below_cur;

    eos_pkg::target_t                  tgt;
    logic                              stop_calc;
    logic                              order_calc;

    assign entry     = pending_reg[cmd.scan_idx];
    assign at_cur    = (eos_pkg::CMP_W'(cmd.scan_idx) == eos_pkg::CMP_W'(floor_reg));
    assign above_cur = (eos_pkg::CMP_W'(cmd.scan_idx) >= eos_pkg::CMP_W'(floor_reg));
    assign below_cur = (eos_pkg::CMP_W'(cmd.scan_idx) <= eos_pkg::CMP_W'(floor_reg));

    always_comb begin
        entry_new = entry;
        hall      = entry[1:0];
        if (at_cur) begin
            case (mode_reg)
                eos_pkg::MODE_ADD: begin
                    if (button_reg <= eos_pkg::BTN_CAB) begin
                        entry_new = entry | (OW'(1) << button_reg);
                    end
                end
                eos_pkg::MODE_REMOVE: begin
                    if (dir_reg == eos_pkg::DIR_UP) begin
                        if (hall[eos_pkg::BIT_UP]) begin
                            hall[eos_pkg::BIT_DOWN] = 1'b0;
                        end
                        hall[eos_pkg::BIT_UP] = 1'b0;
                    end else if (dir_reg == eos_pkg::DIR_DOWN) begin
                        if (hall[eos_pkg::BIT_DOWN]) begin
                            hall[eos_pkg::BIT_UP] = 1'b0;
                        end
                        hall[eos_pkg::BIT_DOWN] = 1'b0;
                    end
                    entry_new = {1'b0, hall};
                end
                default: begin
                    entry_new = entry;
                end
            endcase
        end
    end

    always_comb begin
        up_vld_next    = cmd.scan_first ? '0 : up_vld_reg;
        up_hit_next    = up_hit_reg;
        dn_vld_next    = cmd.scan_first ? '0 : dn_vld_reg;
        dn_hit_next    = dn_hit_reg;
        any_next       = cmd.scan_first ? 1'b0 : any_reg;
        cur_vld_next   = cmd.scan_first ? 1'b0 : cur_vld_reg;
        cur_entry_next = cur_entry_reg;
        any_next       = any_next | (|entry_new);
        if (at_cur) begin
            cur_vld_next   = 1'b1;
            cur_entry_next = entry_new;
        end
        for (int k = 0; k < OW; k++) begin
            if (entry_new[k] && above_cur) begin
                up_vld_next[k] = 1'b1;
                up_hit_next[k] = cmd.scan_idx;
            end
            if (entry_new[k] && below_cur && !dn_vld_next[k]) begin
                dn_vld_next[k] = 1'b1;
                dn_hit_next[k] = cmd.scan_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < eos_pkg::NUM_FLOORS; i++) begin
                pending_reg[i] <= '0;
            end
        end else if (cmd.scan_en && at_cur) begin
            pending_reg[cmd.scan_idx] <= entry_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg   <= s_mode;
            button_reg <= s_button;
            floor_reg  <= s_floor;
            dir_reg    <= s_direction;
        end
        if (cmd.scan_en) begin
            up_vld_reg    <= up_vld_next;
            up_hit_reg    <= up_hit_next;
            dn_vld_reg    <= dn_vld_next;
            dn_hit_reg    <= dn_hit_next;
            any_reg       <= any_next;
            cur_vld_reg   <= cur_vld_next;
            cur_entry_reg <= cur_entry_next;
        end
    end

    always_comb begin
        tgt.found     = 1'b0;
        tgt.floor_idx = '0;
        if (any_reg) begin
            if (dir_reg == eos_pkg::DIR_UP) begin
                tgt = select_up(up_vld_reg, up_hit_reg);
                if (!tgt.found) begin
                    tgt = select_down(dn_vld_reg, dn_hit_reg);
                end
            end else if (dir_reg == eos_pkg::DIR_DOWN) begin
                tgt = select_down(dn_vld_reg, dn_hit_reg);
                if (!tgt.found) begin
                    tgt = select_up(up_vld_reg, up_hit_reg);
                end
            end
        end
    end

    always_comb begin
        stop_calc = 1'b0;
        if (cur_vld_reg) begin
            if (floor_reg == '0 && (cur_entry_reg[eos_pkg::BIT_UP] ||
                                    cur_entry_reg[eos_pkg::BIT_CAB])) begin
                stop_calc = 1'b1;
            end
            if (eos_pkg::CMP_W'(floor_reg) == eos_pkg::CMP_W'(eos_pkg::NUM_FLOORS - 1) &&
                (cur_entry_reg[eos_pkg::BIT_DOWN] || cur_entry_reg[eos_pkg::BIT_CAB])) begin
                stop_calc = 1'b1;
            end
            if (cur_entry_reg[eos_pkg::BIT_CAB]) begin
                stop_calc = 1'b1;
            end
            if (dir_reg == eos_pkg::DIR_UP && cur_entry_reg[eos_pkg::BIT_UP]) begin
                stop_calc = 1'b1;
            end
            if (dir_reg == eos_pkg::DIR_DOWN && cur_entry_reg[eos_pkg::BIT_DOWN]) begin
                stop_calc = 1'b1;
            end
        end
        order_calc = 1'b0;
        if (cur_vld_reg && button_reg <= eos_pkg::BTN_CAB) begin
            order_calc = ((cur_entry_reg >> button_reg) & OW'(1)) != '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            order_set_reg    <= order_calc;
            stop_here_reg    <= stop_calc;
            target_found_reg <= tgt.found;
            target_floor_reg <= tgt.found ? eos_pkg::FLOOR_W'(tgt.floor_idx) : '0;
            any_pending_reg  <= any_reg;
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid        = out_valid_reg;
    assign m_order_set    = order_set_reg;
    assign m_stop_here    = stop_here_reg;
    assign m_target_found = target_found_reg;
    assign m_target_floor = target_floor_reg;
    assign m_any_pending  = any_pending_reg;

endmodule

`default_nettype wire
